/* design/gpgh_pkg.sv */
// ----------------------------------------------------------------------------
// gpgh_pkg
// Shared types, constants and control words for the geo point grid histogram.
// ----------------------------------------------------------------------------
package gpgh_pkg;

    // Grid shape
    localparam int COLS  = 64;
    localparam int ROWS  = 64;
    localparam int NBINS = COLS * ROWS;
    localparam int N_MAX = (COLS > ROWS) ? COLS : ROWS;

    // Field widths
    localparam int CMD_W = 2;
    localparam int LON_W = 29;
    localparam int LAT_W = 28;
    localparam int BIN_W = 12;
    localparam int CNT_W = 32;

    // Stream word layout
    localparam int S_TDATA_W = 72;
    localparam int LON_LSB   = 0;
    localparam int LAT_LSB   = LON_W;
    localparam int IDX_LSB   = LON_W + LAT_W;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - BIN_W - CNT_W;

    // Axis arithmetic: both axes run at longitude width
    localparam int AX_W  = LON_W;
    localparam int REM_W = AX_W + 1;
    localparam int N_W   = $clog2(N_MAX + 1);
    localparam int NUM_W = AX_W + N_W;
    localparam int QW    = (N_MAX > 1) ? $clog2(N_MAX) : 1;
    localparam int DC_W  = (QW > 1) ? $clog2(QW) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = LON_W;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LON_MAX = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_MIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_MAX = CFG_IDX_W'(3);

    // Grid edges after reset
    localparam logic [LON_W-1:0] LON_MIN_RST = LON_W'(104042140);
    localparam logic [LON_W-1:0] LON_MAX_RST = LON_W'(104129580);
    localparam logic [LAT_W-1:0] LAT_MIN_RST = LAT_W'(30652940);
    localparam logic [LAT_W-1:0] LAT_MAX_RST = LAT_W'(30727750);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_READ = 2'd1,
        OUT_INCR = 2'd2
    } t_out_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     check;
        logic     axis;       // 0 longitude, 1 latitude
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     bin_make;
        logic     mem_rd;
        logic     mem_inc;
        logic     clr_step;
        logic     load_out;
        t_out_sel out_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic ok;
        logic div_last;
        logic clr_last;
    } t_dp_sts;

endpackage

/* design/gpgh_ctrl.sv */
// ----------------------------------------------------------------------------
// gpgh_ctrl
// Command sequencer: clear sweep, point mapping, bin read/increment, output
// register handoff.
// ----------------------------------------------------------------------------
module gpgh_ctrl
    import gpgh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_DINIT = 10'b0000010000,
        S_DSTEP = 10'b0000100000,
        S_BIN   = 10'b0001000000,
        S_RD    = 10'b0010000000,
        S_INC   = 10'b0100000000,
        S_RES   = 10'b1000000000
    } t_state;

    t_state   r_state, n_state;
    t_out_sel r_sel, n_sel;
    logic     r_axis, n_axis;
    logic     r_clr_reply, n_clr_reply;
    logic     r_out_valid, n_out_valid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_axis        = r_axis;
        n_clr_reply   = r_clr_reply;
        o_cmd         = '0;
        o_cmd.axis    = r_axis;
        o_cmd.out_sel = r_sel;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_clr_reply = 1'b0;
                    if (r_clr_reply) begin
                        n_sel   = OUT_ZERO;
                        n_state = S_RES;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                case (i_sts.cmd)
                    CMD_ADD: begin
                        if (i_sts.ok) begin
                            n_axis  = 1'b0;
                            n_state = S_MUL;
                        end else begin
                            n_sel   = OUT_ZERO;
                            n_state = S_RES;
                        end
                    end
                    CMD_READ: begin
                        if (i_sts.ok) begin
                            n_state = S_RD;
                        end else begin
                            n_sel   = OUT_ZERO;
                            n_state = S_RES;
                        end
                    end
                    CMD_CLEAR: begin
                        n_clr_reply = 1'b1;
                        n_state     = S_CLEAR;
                    end
                    default: begin
                        n_sel   = OUT_ZERO;
                        n_state = S_RES;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_BIN;
                    end
                end
            end
            S_BIN: begin
                o_cmd.bin_make = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                if (i_sts.cmd == CMD_ADD) begin
                    n_state = S_INC;
                end else begin
                    n_sel   = OUT_READ;
                    n_state = S_RES;
                end
            end
            S_INC: begin
                o_cmd.mem_inc = 1'b1;
                n_sel         = OUT_INCR;
                n_state       = S_RES;
            end
            S_RES: begin
                // hold until the output register is free or being drained
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop when the word is taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_m_tready) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sel       <= OUT_ZERO;
            r_axis      <= 1'b0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_axis      <= n_axis;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/gpgh_dpath.sv */
// ----------------------------------------------------------------------------
// gpgh_dpath
// Grid edges, range checks, shared bit-serial cell divider, bin memory with
// saturating increment, clear sweep counter and output register.
// ----------------------------------------------------------------------------
module gpgh_dpath
    import gpgh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tuser
);

    // Grid edges
    logic [LON_W-1:0] r_lon_min, r_lon_max;
    logic [LAT_W-1:0] r_lat_min, r_lat_max;

    // Latched input word
    t_cmd             r_cmd;
    logic [LON_W-1:0] r_lon;
    logic [LAT_W-1:0] r_lat;
    logic [BIN_W-1:0] r_idx;

    // Axis offsets and spans
    logic [AX_W-1:0]  r_off_lon, r_off_lat, r_span_lon, r_span_lat;

    // Divider
    logic [NUM_W-1:0] r_num;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [QW-1:0]    r_quo, n_quo;
    logic [DC_W-1:0]  r_div_cnt;
    logic [QW-1:0]    r_col, r_row;

    // Bin memory
    logic [CNT_W-1:0] mem [NBINS];
    logic [CNT_W-1:0] r_rdata;
    logic [BIN_W-1:0] r_addr;
    logic [BIN_W-1:0] r_clr_addr;

    // Output register
    logic             r_o_range;
    logic [BIN_W-1:0] r_o_bin;
    logic [CNT_W-1:0] r_o_count;

    logic signed [AX_W-1:0] w_lon_p, w_lon_lo, w_lon_hi;
    logic signed [AX_W-1:0] w_lat_p, w_lat_lo, w_lat_hi;
    logic                   w_lon_ok, w_lat_ok, w_ok;
    logic [AX_W:0]          w_lon_off, w_lon_span, w_lat_off, w_lat_span;
    logic [AX_W-1:0]        w_off, w_span;
    logic [N_W-1:0]         w_n;
    logic [NUM_W-1:0]       w_prod;
    logic [QW-1:0]          w_nlow;
    logic [REM_W-1:0]       w_trial;
    logic                   w_ge;
    logic                   w_div_last;
    logic                   w_clr_last;
    logic [CNT_W-1:0]       w_inc;
    logic                   w_we;
    logic [BIN_W-1:0]       w_waddr;
    logic [CNT_W-1:0]       w_wdata;

    // Configuration writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lon_min <= LON_MIN_RST;
            r_lon_max <= LON_MAX_RST;
            r_lat_min <= LAT_MIN_RST;
            r_lat_max <= LAT_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LON_MIN: r_lon_min <= i_cfg_data[LON_W-1:0];
                CFG_LON_MAX: r_lon_max <= i_cfg_data[LON_W-1:0];
                CFG_LAT_MIN: r_lat_min <= i_cfg_data[LAT_W-1:0];
                CFG_LAT_MAX: r_lat_max <= i_cfg_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= t_cmd'(i_s_tuser);
            r_lon <= i_s_tdata[LON_LSB +: LON_W];
            r_lat <= i_s_tdata[LAT_LSB +: LAT_W];
            r_idx <= i_s_tdata[IDX_LSB +: BIN_W];
        end
    end

    // Range checks: lo <= p < hi also rules out an empty span
    assign w_lon_p  = r_lon;
    assign w_lon_lo = r_lon_min;
    assign w_lon_hi = r_lon_max;
    assign w_lat_p  = {r_lat[LAT_W-1], r_lat};
    assign w_lat_lo = {r_lat_min[LAT_W-1], r_lat_min};
    assign w_lat_hi = {r_lat_max[LAT_W-1], r_lat_max};

    assign w_lon_ok = (w_lon_p >= w_lon_lo) && (w_lon_p < w_lon_hi);
    assign w_lat_ok = (w_lat_p >= w_lat_lo) && (w_lat_p < w_lat_hi);

    assign w_lon_off  = {w_lon_p[AX_W-1], w_lon_p} - {w_lon_lo[AX_W-1], w_lon_lo};
    assign w_lon_span = {w_lon_hi[AX_W-1], w_lon_hi} - {w_lon_lo[AX_W-1], w_lon_lo};
    assign w_lat_off  = {w_lat_p[AX_W-1], w_lat_p} - {w_lat_lo[AX_W-1], w_lat_lo};
    assign w_lat_span = {w_lat_hi[AX_W-1], w_lat_hi} - {w_lat_lo[AX_W-1], w_lat_lo};

    always_comb begin
        case (r_cmd)
            CMD_ADD:  w_ok = w_lon_ok && w_lat_ok;
            CMD_READ: w_ok = (int'(r_idx) < NBINS);
            default:  w_ok = 1'b0;
        endcase
    end

    // Capture offsets and spans; a read takes its address here
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_off_lon  <= w_lon_off[AX_W-1:0];
            r_span_lon <= w_lon_span[AX_W-1:0];
            r_off_lat  <= w_lat_off[AX_W-1:0];
            r_span_lat <= w_lat_span[AX_W-1:0];
        end
    end

    // Divider: quotient of off*n / span, one bit a cycle, MSB first
    assign w_off  = i_cmd.axis ? r_off_lat  : r_off_lon;
    assign w_span = i_cmd.axis ? r_span_lat : r_span_lon;
    assign w_n    = i_cmd.axis ? N_W'(ROWS) : N_W'(COLS);
    assign w_prod = w_off * w_n;

    assign w_nlow     = r_num[QW-1:0];
    assign w_trial    = {r_rem[REM_W-2:0], w_nlow[r_div_cnt]};
    assign w_ge       = (w_trial >= {1'b0, w_span});
    assign n_rem      = w_ge ? (w_trial - {1'b0, w_span}) : w_trial;
    assign n_quo      = QW'({r_quo, w_ge});
    assign w_div_last = (r_div_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= w_prod;
        end
        if (i_cmd.div_init) begin
            // off < span, so the high part already sits below span
            r_rem     <= REM_W'(r_num >> QW);
            r_quo     <= '0;
            r_div_cnt <= DC_W'(QW - 1);
        end else if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_quo     <= n_quo;
            r_div_cnt <= r_div_cnt - 1'b1;
            if (w_div_last) begin
                if (i_cmd.axis) begin
                    r_row <= n_quo;
                end else begin
                    r_col <= n_quo;
                end
            end
        end
    end

    // Bin address
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_addr <= r_idx;
        end else if (i_cmd.bin_make) begin
            r_addr <= BIN_W'(int'(r_col) * ROWS + int'(r_row));
        end
    end

    // Clear sweep counter
    assign w_clr_last = (r_clr_addr == BIN_W'(NBINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    // Bin memory: one write port, registered read
    assign w_inc   = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
    assign w_we    = i_cmd.clr_step || i_cmd.mem_inc;
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clr_step ? '0 : w_inc;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (i_cmd.out_sel)
                OUT_READ: begin
                    r_o_range <= 1'b1;
                    r_o_bin   <= r_addr;
                    r_o_count <= r_rdata;
                end
                OUT_INCR: begin
                    r_o_range <= 1'b1;
                    r_o_bin   <= r_addr;
                    r_o_count <= w_inc;
                end
                default: begin
                    r_o_range <= 1'b0;
                    r_o_bin   <= '0;
                    r_o_count <= '0;
                end
            endcase
        end
    end

    assign o_m_tdata = {{M_PAD_W{1'b0}}, r_o_count, r_o_bin};
    assign o_m_tuser = r_o_range;

    assign o_sts.cmd      = r_cmd;
    assign o_sts.ok       = w_ok;
    assign o_sts.div_last = w_div_last;
    assign o_sts.clr_last = w_clr_last;

`ifndef ASSERT_OFF
    a_col_below_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && w_div_last && !i_cmd.axis) |-> (int'(n_quo) < COLS))
        else $error("column quotient out of grid");
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < {1'b0, w_span}))
        else $error("divider remainder not below span");
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_step && i_cmd.mem_inc))
        else $error("clear sweep and increment write together");
`endif

endmodule

/* design/geo_point_grid_histogram_core.sv */
// ----------------------------------------------------------------------------
// geo_point_grid_histogram_core
// Two-dimensional histogram of geographic points on a configurable grid.
// ----------------------------------------------------------------------------
// Each input word carries a command: add point, read bin, clear all bins.
// An added point maps to column floor((lon-lon_min)*COLS/span) and row the
// same for latitude, and bumps bin column*ROWS+row (saturating at all ones);
// points outside [min,max) on either axis are dropped with in_range low.
// Every word returns exactly one result word. After reset the block sweeps
// the 4096-entry bin memory to zero, one bin a cycle, before taking its
// first word; a clear command runs the same sweep before its result. For an
// add point the shared divider produces one quotient bit a cycle for each
// axis in turn, followed by a read, increment and write of the bin memory,
// which has one write port. A read bin skips the divider. One word is
// worked at a time; a finished result waits in the output register while
// the next word is taken. Write grid edges only while the block is idle.
// ----------------------------------------------------------------------------
module geo_point_grid_histogram_core
    import gpgh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // longitude[28:0], latitude[56:29],
                                              // read_index[68:57], zero pad
    input  logic [CMD_W-1:0]      i_s_tuser,  // cmd[1:0]
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // bin_index[11:0], count[43:12], zero pad
    output logic                  o_m_tuser   // in_range[0]
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Edges are plain registers: always take a write
    assign o_cfg_ready = 1'b1;

    gpgh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gpgh_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the geo point grid histogram core.
// ----------------------------------------------------------------------------
// An initial block queues command words phase by phase and rewrites the grid
// edges between phases, once the core has gone idle. A clocked driver presents
// the words with random gaps. Each accepted word runs through a local copy of
// the grid and the bin store, and the result that copy predicts is queued.
// A clocked monitor stalls the result stream at random. It compares each
// result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gpgh_pkg::*;

    typedef struct {
        t_cmd                    cmd;
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic [BIN_W-1:0]        rd_idx;
    } grid_word_t;

    typedef struct {
        logic             in_range;
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] count;
    } bin_result_t;

    localparam longint LON_LIM = 180000000;
    localparam longint LAT_LIM = 90000000;
    localparam longint LON_TOP = 268435455;   // largest 29-bit signed value
    localparam longint LAT_TOP = 134217727;   // largest 28-bit signed value
    localparam int     DRAIN_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [CMD_W-1:0]      i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;

    // Predicted grid edges and bin store
    longint           lon_lo = longint'($signed(LON_MIN_RST));
    longint           lon_hi = longint'($signed(LON_MAX_RST));
    longint           lat_lo = longint'($signed(LAT_MIN_RST));
    longint           lat_hi = longint'($signed(LAT_MAX_RST));
    logic [CNT_W-1:0] bin_tally [NBINS];
    int               touched_bins[$];

    grid_word_t  point_words[$];
    bin_result_t bin_results_due[$];
    grid_word_t  word_out;
    bin_result_t want;
    int          send_gap = 0;
    int          take_gap = 0;
    int          mismatch_cnt = 0;
    bit          calm = 1'b0;
    bit          odd_index_seen = 1'b0;

    geo_point_grid_histogram_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // longitude, latitude, read_index, zero pad
        .i_s_tuser   (i_s_tuser),   // cmd
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // bin_index, count, zero pad
        .o_m_tuser   (o_m_tuser)    // in_range
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
    end

    // Cell along one axis, or -1 when outside [lo, hi) or the span is empty
    function automatic int axis_cell(longint p, longint lo, longint hi, int n);
        if (hi <= lo || p < lo || p >= hi) return -1;
        return int'(((p - lo) * n) / (hi - lo));
    endfunction

    // Apply one command word to the local store and return its result word
    function automatic bin_result_t tally_word(grid_word_t w);
        bin_result_t r;
        int          col;
        int          row;
        int          b;
        r = '{in_range: 1'b0, bin_index: '0, count: '0};
        case (w.cmd)
            CMD_ADD: begin
                col = axis_cell(longint'(w.lon), lon_lo, lon_hi, COLS);
                row = axis_cell(longint'(w.lat), lat_lo, lat_hi, ROWS);
                if (col >= 0 && row >= 0 && col * ROWS + row < NBINS) begin
                    b = col * ROWS + row;
                    if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1;
                    r.in_range  = 1'b1;
                    r.bin_index = BIN_W'(b);
                    r.count     = bin_tally[b];
                    touched_bins.push_back(b);
                    if (touched_bins.size() > 16) void'(touched_bins.pop_front());
                end
            end
            CMD_READ: begin
                if (int'(w.rd_idx) < NBINS) begin
                    r.in_range  = 1'b1;
                    r.bin_index = w.rd_idx;
                    r.count     = bin_tally[w.rd_idx];
                end
            end
            CMD_CLEAR: begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Coordinate on one axis: mostly inside the grid, some on the edges,
    // some crowded into the first cell, the rest anywhere in the field
    function automatic longint pick_coord(longint lo, longint hi, int n);
        int sel;
        sel = $urandom_range(0, 19);
        if (hi <= lo || sel < 2) return longint'($urandom);
        if (sel == 2) return lo;
        if (sel == 3) return hi - 1;
        if (sel == 4) return hi;
        if (sel == 5) return lo - 1;
        if (sel < 10) return lo + longint'($urandom_range(0, 32'((hi - lo - 1) / n)));
        return lo + longint'($urandom_range(0, 32'(hi - lo - 1)));
    endfunction

    function automatic grid_word_t random_word();
        grid_word_t w;
        int         pick;
        w.cmd    = CMD_NOP;
        w.lon    = LON_W'($urandom);
        w.lat    = LAT_W'($urandom);
        w.rd_idx = BIN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            w.cmd = CMD_ADD;
            w.lon = LON_W'(pick_coord(lon_lo, lon_hi, COLS));
            w.lat = LAT_W'(pick_coord(lat_lo, lat_hi, ROWS));
        end else if (pick < 95) begin
            w.cmd = CMD_READ;
            if (touched_bins.size() != 0 && $urandom_range(0, 4) < 3)
                w.rd_idx = BIN_W'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]);
        end else if (pick < 97) begin
            w.cmd = CMD_CLEAR;
        end
        return w;
    endfunction

    task automatic push_word(t_cmd c, longint lon, longint lat, int idx);
        grid_word_t w;
        w.cmd    = c;
        w.lon    = LON_W'(lon);
        w.lat    = LAT_W'(lat);
        w.rd_idx = BIN_W'(idx);
        point_words.push_back(w);
    endtask

    // Present one register write; valid is left high for a following write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LON_MIN: lon_lo = longint'($signed(data));
            CFG_LON_MAX: lon_hi = longint'($signed(data));
            CFG_LAT_MIN: lat_lo = longint'($signed(data[LAT_W-1:0]));
            CFG_LAT_MAX: lat_hi = longint'($signed(data[LAT_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (point_words.size() != 0 || i_s_tvalid || bin_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Drain, rewrite the grid edges, then queue a batch of random words
    task automatic run_phase(longint lon_a, longint lon_b, longint lat_a, longint lat_b,
                             int n_words, bit quiet);
        wait_drained();
        @(posedge i_clk);
        cfg_write(CFG_LON_MIN, CFG_DATA_W'(lon_a));
        if (!odd_index_seen) cfg_write('1, CFG_DATA_W'($urandom));
        else cfg_write(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
        odd_index_seen = 1'b1;
        cfg_write(CFG_LON_MAX, CFG_DATA_W'(lon_b));
        cfg_write(CFG_LAT_MIN, CFG_DATA_W'(lat_a));
        cfg_write(CFG_LAT_MAX, CFG_DATA_W'(lat_b));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        calm = quiet;
        repeat (n_words) point_words.push_back(random_word());
    endtask

    // Stimulus
    initial begin
        longint lo;
        longint la;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words on the reset grid
        push_word(CMD_READ, 0, 0, 0);
        push_word(CMD_READ, -1, -1, NBINS - 1);
        push_word(CMD_ADD, lon_lo, lat_lo, NBINS - 1);
        push_word(CMD_ADD, lon_hi - 1, lat_hi - 1, 0);
        push_word(CMD_ADD, lon_hi, lat_lo, 0);
        push_word(CMD_ADD, lon_lo - 1, lat_lo, 0);
        push_word(CMD_ADD, lon_lo, lat_hi, 0);
        push_word(CMD_ADD, lon_lo, lat_lo - 1, 0);
        push_word(CMD_ADD, -LON_LIM, -LAT_LIM, 0);
        push_word(CMD_ADD, LON_LIM, LAT_LIM, 0);
        push_word(CMD_ADD, -LON_TOP - 1, -LAT_TOP - 1, 0);
        push_word(CMD_ADD, LON_TOP, LAT_TOP, NBINS - 1);
        push_word(CMD_ADD, lon_lo, lat_lo, 0);
        push_word(CMD_READ, 0, 0, 0);
        push_word(CMD_READ, 0, 0, NBINS - 1);
        push_word(CMD_NOP, -1, -1, NBINS - 1);
        push_word(CMD_READ, LON_TOP, LAT_TOP, 0);
        push_word(CMD_CLEAR, -1, -1, NBINS - 1);
        push_word(CMD_READ, 0, 0, 0);
        push_word(CMD_READ, 0, 0, NBINS - 1);
        push_word(CMD_ADD, (lon_lo + lon_hi) / 2, (lat_lo + lat_hi) / 2, 0);
        push_word(CMD_READ, 0, 0, 32 * ROWS + 32);
        push_word(CMD_NOP, 0, 0, 0);

        // Whole world
        run_phase(-LON_LIM, LON_LIM, -LAT_LIM, LAT_LIM, 250, 1'b0);
        // Narrow local grid, so that bins fill up
        lo = -LON_LIM + longint'($urandom_range(0, 359000000));
        la = -LAT_LIM + longint'($urandom_range(0, 179000000));
        run_phase(lo, lo + longint'($urandom_range(64, 4000)),
                  la, la + longint'($urandom_range(64, 4000)), 250, 1'b0);
        // Spans shorter than the grid, many cells unreachable
        run_phase(lo, lo + longint'($urandom_range(1, 63)), la, la + 1, 150, 1'b0);
        // Empty spans: equal edges, then reversed edges
        run_phase(lo, lo, -LAT_LIM, LAT_LIM, 60, 1'b0);
        run_phase(-LON_LIM, LON_LIM, la, la - longint'($urandom_range(1, 1000)), 60, 1'b0);
        // Edges at the limits of the register width
        run_phase(-LON_TOP - 1, LON_TOP, -LAT_TOP - 1, LAT_TOP, 200, 1'b0);
        run_phase(LON_TOP, -LON_TOP - 1, LAT_TOP, -LAT_TOP - 1, 40, 1'b0);
        // Back to the reset grid, no idling on either side
        run_phase(longint'($signed(LON_MIN_RST)), longint'($signed(LON_MAX_RST)),
                  longint'($signed(LAT_MIN_RST)), longint'($signed(LAT_MAX_RST)),
                  250, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Drive command words; predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) bin_results_due.push_back(tally_word(word_out));
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (point_words.size() != 0) begin
                    word_out = point_words.pop_front();
                    i_s_tdata  <= S_TDATA_W'({word_out.rd_idx, word_out.lat, word_out.lon});
                    i_s_tuser  <= word_out.cmd;
                    i_s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check result words against the oldest prediction; stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (bin_results_due.size() == 0) begin
                    $error("result word with none due: bin_index %0d, count %0d",
                           o_m_tdata[BIN_W-1:0], o_m_tdata[BIN_W +: CNT_W]);
                    mismatch_cnt++;
                end else begin
                    want = bin_results_due.pop_front();
                    if (o_m_tuser !== want.in_range) begin
                        $error("in_range: expected %0d, actual %0d", want.in_range, o_m_tuser);
                        mismatch_cnt++;
                    end
                    if (o_m_tdata[BIN_W-1:0] !== want.bin_index) begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.bin_index, o_m_tdata[BIN_W-1:0]);
                        mismatch_cnt++;
                    end
                    if (o_m_tdata[BIN_W +: CNT_W] !== want.count) begin
                        $error("count: expected %0d, actual %0d",
                               want.count, o_m_tdata[BIN_W +: CNT_W]);
                        mismatch_cnt++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap = take_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(1, 14) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
design/gpgh_pkg.sv
design/gpgh_ctrl.sv
design/gpgh_dpath.sv
design/geo_point_grid_histogram_core.sv
tb/sv/tb_top.sv
